// ===== hw/rtl/sorted_priority_queue_macros.svh =====
// Assertion macros for the port-level queue checker.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Shared constants, command codes and control types of the priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int QueueDepth = 16;
   localparam int TagWidth   = 32;
   localparam int PortTagWidth = 32;
   localparam int PrioWidth  = 32;
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam int IdxWidth   = $clog2(QueueDepth);

   typedef enum logic [1:0] {
      OpInsert = 2'd0,
      OpTop    = 2'd1,
      OpPop    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      StOk    = 2'd0,
      StEmpty = 2'd1,
      StFull  = 2'd2
   } status_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                  insert;
      logic                  pop;
      logic [CountWidth-1:0] count;
   } cmd_type;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and a chain of cells.
//
//   channel   ports                                        handshake
//   request   req_op, req_item_tag, req_item_priority      start && !busy
//   result    rsp_status, rsp_head_tag, rsp_head_priority  rsp_valid strobe
//
// One command is taken every cycle; busy stays low.
// Each result strobes for one cycle, the cycle after its command beat.
// Every cell compares its own priority with the new one in parallel and
// shifts by one place.
// Reset empties the queue at once; stored entries are not cleared.
// The receiver cannot stall, so nothing holds the chain.
`timescale 1ns / 1ps

module sorted_priority_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_op,
   input  logic [spq_pkg::PortTagWidth-1:0]      req_item_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0]  req_item_priority,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [spq_pkg::PortTagWidth-1:0]      rsp_head_tag,
   output logic signed [spq_pkg::PrioWidth-1:0]  rsp_head_priority
);

   localparam int Depth = spq_pkg::QueueDepth;

   spq_pkg::cmd_type                     cmd;
   logic                                 accept;
   logic [spq_pkg::TagWidth-1:0]         new_tag;
   logic                                 le_chain   [Depth];
   logic [spq_pkg::TagWidth-1:0]         tag_chain  [Depth];
   logic signed [spq_pkg::PrioWidth-1:0] prio_chain [Depth];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign new_tag = req_item_tag[spq_pkg::TagWidth-1:0];

   spq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_op            (req_op),
      .head_tag          (tag_chain[0]),
      .head_prio         (prio_chain[0]),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_tag      (rsp_head_tag),
      .rsp_head_priority (rsp_head_priority)
   );

   // Build the row of cells, head at index zero.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic                                 l_le;
      logic [spq_pkg::TagWidth-1:0]         l_tag, r_tag;
      logic signed [spq_pkg::PrioWidth-1:0] l_prio, r_prio;

      if (i == 0) begin : g_head
         assign l_le   = 1'b0;
         assign l_tag  = '0;
         assign l_prio = '0;
      end else begin : g_mid
         assign l_le   = le_chain[i-1];
         assign l_tag  = tag_chain[i-1];
         assign l_prio = prio_chain[i-1];
      end

      if (i == Depth - 1) begin : g_tail
         assign r_tag  = '0;
         assign r_prio = '0;
      end else begin : g_body
         assign r_tag  = tag_chain[i+1];
         assign r_prio = prio_chain[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (spq_pkg::IdxWidth'(i)),
         .new_tag    (new_tag),
         .new_prio   (req_item_priority),
         .left_le    (l_le),
         .left_tag   (l_tag),
         .left_prio  (l_prio),
         .right_tag  (r_tag),
         .right_prio (r_prio),
         .le         (le_chain[i]),
         .tag        (tag_chain[i]),
         .prio       (prio_chain[i])
      );
   end

endmodule

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted chain: holds a single entry.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                              clock,
   input  spq_pkg::cmd_type                  cmd,
   input  logic [spq_pkg::IdxWidth-1:0]      cell_index,
   input  logic [spq_pkg::TagWidth-1:0]      new_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0] new_prio,
   input  logic                              left_le,
   input  logic [spq_pkg::TagWidth-1:0]      left_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0] left_prio,
   input  logic [spq_pkg::TagWidth-1:0]      right_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0] right_prio,
   output logic                              le,
   output logic [spq_pkg::TagWidth-1:0]      tag,
   output logic signed [spq_pkg::PrioWidth-1:0] prio
);

   logic [spq_pkg::TagWidth-1:0]         tag_ff, tag_in;
   logic signed [spq_pkg::PrioWidth-1:0] prio_ff, prio_in;
   logic                                 valid;

   // Entry is live when it sits below the fill count.
   assign valid = spq_pkg::CountWidth'(cell_index) < cmd.count;

   // New entry belongs at or before this cell.
   assign le = !valid || (prio_ff <= new_prio);

   // Pick the next content: on insert, shift right or take the new entry; shift left on pop.
   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      priority if (cmd.insert && le) begin
         if (left_le) begin
            tag_in  = left_tag;
            prio_in = left_prio;
         end else begin
            tag_in  = new_tag;
            prio_in = new_prio;
         end
      end else if (cmd.pop) begin
         tag_in  = right_tag;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign tag  = tag_ff;
   assign prio = prio_ff;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Command decode, fill count and result register of the priority queue.
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [1:0]                            req_op,
   input  logic [spq_pkg::TagWidth-1:0]          head_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0]  head_prio,
   output spq_pkg::cmd_type                      cmd,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [spq_pkg::PortTagWidth-1:0]      rsp_head_tag,
   output logic signed [spq_pkg::PrioWidth-1:0]  rsp_head_priority
);

   logic [spq_pkg::CountWidth-1:0]         count_ff, count_in;
   logic                                   valid_ff, valid_in;
   spq_pkg::status_type                    status_ff, status_in;
   logic [spq_pkg::PortTagWidth-1:0]       htag_ff, htag_in;
   logic signed [spq_pkg::PrioWidth-1:0]   hprio_ff, hprio_in;
   logic                                   full;
   logic                                   empty;
   logic                                   do_insert;
   logic                                   do_pop;

   assign full  = count_ff == spq_pkg::CountWidth'(spq_pkg::QueueDepth);
   assign empty = count_ff == '0;

   // Decode the beat into a cell command and its status.
   always_comb begin
      do_insert = 1'b0;
      do_pop    = 1'b0;
      status_in = spq_pkg::StOk;
      htag_in   = '0;
      hprio_in  = '0;
      unique case (spq_pkg::op_type'(req_op))
         spq_pkg::OpInsert: begin
            if (full) status_in = spq_pkg::StFull;
            else do_insert = accept;
         end
         spq_pkg::OpTop: begin
            if (empty) begin
               status_in = spq_pkg::StEmpty;
            end else begin
               htag_in  = spq_pkg::PortTagWidth'(head_tag);
               hprio_in = head_prio;
            end
         end
         spq_pkg::OpPop: begin
            if (empty) status_in = spq_pkg::StEmpty;
            else do_pop = accept;
         end
         default: begin
         end
      endcase
   end

   // Advance the fill count.
   always_comb begin
      count_in = count_ff;
      if (do_insert) count_in = count_ff + 1'b1;
      else if (do_pop) count_in = count_ff - 1'b1;
   end

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the result payload for its one-cycle strobe.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      htag_ff   <= htag_in;
      hprio_ff  <= hprio_in;
   end

   assign cmd.insert = do_insert;
   assign cmd.pop    = do_pop;
   assign cmd.count  = count_ff;

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_tag      = htag_ff;
   assign rsp_head_priority = hprio_ff;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [1:0]                            req_op,
   input logic                                  rsp_valid,
   input logic [1:0]                            rsp_status,
   input logic [spq_pkg::PortTagWidth-1:0]      rsp_head_tag,
   input logic signed [spq_pkg::PrioWidth-1:0]  rsp_head_priority
);

   // Every command beat yields a result strobe in the next cycle, and nothing else does.
   `SPQ_ASSERT_NEXT(a_rsp_follows_cmd, start && !busy, rsp_valid, "result strobe missing")
   `SPQ_ASSERT_NEXT(a_no_stray_rsp, !(start && !busy), !rsp_valid, "result without command")

   // Only a top carries head data.
   `SPQ_ASSERT(a_head_only_on_top,
      rsp_valid && $past(req_op) != spq_pkg::OpTop |->
         rsp_head_tag == '0 && rsp_head_priority == '0,
      "head data on a command other than top")

   // Empty status only answers a top or a pop; full only answers an insert.
   `SPQ_ASSERT(a_empty_cause,
      rsp_valid && rsp_status == spq_pkg::StEmpty |->
         $past(req_op) == spq_pkg::OpTop || $past(req_op) == spq_pkg::OpPop,
      "empty status on wrong command")
   `SPQ_ASSERT(a_full_cause,
      rsp_valid && rsp_status == spq_pkg::StFull |-> $past(req_op) == spq_pkg::OpInsert,
      "full status on wrong command")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_head_tag      (rsp_head_tag),
   .rsp_head_priority (rsp_head_priority)
);

// ===== sim/sorted_priority_queue_checker.sv =====
// Scoreboard for the sorted priority queue: predicts each result and checks the result channel.
`timescale 1ns / 1ps

module sorted_priority_queue_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [1:0]                             req_op,
   input  logic [spq_pkg::PortTagWidth-1:0]       req_item_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0]   req_item_priority,
   input  logic                                   rsp_valid,
   input  logic [1:0]                             rsp_status,
   input  logic [spq_pkg::PortTagWidth-1:0]       rsp_head_tag,
   input  logic signed [spq_pkg::PrioWidth-1:0]   rsp_head_priority,
   output int                                     fail_count,
   output int                                     open_count
);

   typedef struct packed {
      spq_pkg::status_type                status;
      logic [spq_pkg::PortTagWidth-1:0]   tag;
      logic [spq_pkg::PrioWidth-1:0]      prio;
   } head_result_type;

   // Own copy of the queue contents, head at index zero.
   logic [spq_pkg::PortTagWidth-1:0]     held_tags [spq_pkg::QueueDepth];
   logic signed [spq_pkg::PrioWidth-1:0] held_prios [spq_pkg::QueueDepth];
   int                                   held_count;

   head_result_type due_results [$];

   // Apply one command to the queue copy and return the result it gives.
   function automatic head_result_type serve_command(
         logic [1:0] op,
         logic [spq_pkg::PortTagWidth-1:0] tag,
         logic signed [spq_pkg::PrioWidth-1:0] prio);
      head_result_type res;
      int              pos;
      res.status = spq_pkg::StOk;
      res.tag    = '0;
      res.prio   = '0;
      case (op)
         spq_pkg::OpInsert: begin
            if (held_count >= spq_pkg::QueueDepth) begin
               res.status = spq_pkg::StFull;
            end else begin
               // Skip entries that strictly outrank the new one; ties go behind it.
               pos = 0;
               while (pos < held_count && held_prios[pos] > prio) pos++;
               for (int k = held_count; k > pos; k--) begin
                  held_tags[k]  = held_tags[k-1];
                  held_prios[k] = held_prios[k-1];
               end
               // Keep only the stored tag bits.
               held_tags[pos]  = spq_pkg::PortTagWidth'(tag[spq_pkg::TagWidth-1:0]);
               held_prios[pos] = prio;
               held_count++;
            end
         end
         spq_pkg::OpTop: begin
            if (held_count == 0) begin
               res.status = spq_pkg::StEmpty;
            end else begin
               res.tag  = held_tags[0];
               res.prio = held_prios[0];
            end
         end
         spq_pkg::OpPop: begin
            if (held_count == 0) begin
               res.status = spq_pkg::StEmpty;
            end else begin
               for (int k = 0; k + 1 < held_count; k++) begin
                  held_tags[k]  = held_tags[k+1];
                  held_prios[k] = held_prios[k+1];
               end
               held_count--;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   initial begin
      fail_count = 0;
      open_count = 0;
      held_count = 0;
   end

   // Queue the prediction of each command beat, then check each result beat.
   always @(posedge clock) begin
      head_result_type want;
      if (reset) begin
         held_count = 0;
         due_results.delete();
      end else begin
         if (start && !busy)
            due_results.push_back(serve_command(req_op, req_item_tag, req_item_priority));
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $display("%0t: result with none expected: status %0d tag %h priority %0d",
                        $time, rsp_status, rsp_head_tag, rsp_head_priority);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_head_tag !== want.tag) begin
                  $display("%0t: head_tag expected %h actual %h",
                           $time, want.tag, rsp_head_tag);
                  fail_count++;
               end
               if (rsp_head_priority !== want.prio) begin
                  $display("%0t: head_priority expected %0d actual %0d",
                           $time, $signed(want.prio), rsp_head_priority);
                  fail_count++;
               end
            end
         end
      end
      open_count = due_results.size();
   end

endmodule

// ===== sim/sorted_priority_queue_tb.sv =====
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

   // Op code left unused by the block; it must act as a no-op.
   localparam logic [1:0] OpUnused = 2'd3;
   localparam int RandomPerPhase = 225;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [1:0]                           req_op;
   logic [spq_pkg::PortTagWidth-1:0]     req_item_tag;
   logic signed [spq_pkg::PrioWidth-1:0] req_item_priority;
   logic                                 rsp_valid;
   logic [1:0]                           rsp_status;
   logic [spq_pkg::PortTagWidth-1:0]     rsp_head_tag;
   logic signed [spq_pkg::PrioWidth-1:0] rsp_head_priority;
   int                                   fail_count;
   int                                   open_count;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_item_tag      (req_item_tag),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_tag      (rsp_head_tag),
      .rsp_head_priority (rsp_head_priority)
   );

   sorted_priority_queue_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_item_tag      (req_item_tag),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_tag      (rsp_head_tag),
      .rsp_head_priority (rsp_head_priority),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   always #5 clock = ~clock;

   // Idle at random, then drive one command and hold it until its beat is taken.
   task automatic issue_command(input logic [1:0] op,
                                input logic [spq_pkg::PortTagWidth-1:0] tag,
                                input logic [spq_pkg::PrioWidth-1:0] prio,
                                input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start             <= 1'b0;
         req_op            <= 2'($urandom);
         req_item_tag      <= $urandom;
         req_item_priority <= $urandom;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_op            <= op;
      req_item_tag      <= tag;
      req_item_priority <= prio;
      // busy only moves on a rising edge, so read it mid-cycle.
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Priorities: mostly a narrow band for ties, some extremes, some full range.
   function automatic logic [spq_pkg::PrioWidth-1:0] pick_priority();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50)
         return spq_pkg::PrioWidth'($signed($urandom_range(8)) - 4);
      if (roll < 70) begin
         case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int          idle_pct [4];
      logic        filling;
      int          roll;
      logic [1:0]  op;
      int          drain_cycles;

      idle_pct = '{0, 69, 0, 31};
      reset             <= 1'b1;
      start             <= 1'b0;
      req_op            <= spq_pkg::OpInsert;
      req_item_tag      <= '0;
      req_item_priority <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty-queue commands and the unused op code.
      issue_command(spq_pkg::OpTop, $urandom, $urandom, 0);
      issue_command(spq_pkg::OpPop, $urandom, $urandom, 0);
      issue_command(OpUnused, $urandom, $urandom, 0);
      // Field extremes and equal priorities, then fill to the top.
      issue_command(spq_pkg::OpInsert, 32'h0000_0000, 32'h7FFF_FFFF, 0);
      issue_command(spq_pkg::OpInsert, 32'hFFFF_FFFF, 32'h8000_0000, 0);
      issue_command(spq_pkg::OpInsert, 32'h0000_0001, 32'h0000_0000, 0);
      issue_command(spq_pkg::OpInsert, 32'h0000_0002, 32'h0000_0000, 0);
      issue_command(spq_pkg::OpInsert, 32'h0000_0003, 32'hFFFF_FFFF, 0);
      repeat (spq_pkg::QueueDepth - 5)
         issue_command(spq_pkg::OpInsert, $urandom, pick_priority(), 0);
      // Insert into a full queue gets dropped.
      issue_command(spq_pkg::OpInsert, $urandom, 32'h7FFF_FFFF, 0);
      issue_command(spq_pkg::OpTop, $urandom, $urandom, 0);
      issue_command(spq_pkg::OpPop, $urandom, $urandom, 0);
      issue_command(spq_pkg::OpTop, $urandom, $urandom, 0);

      // Random walk that swings between filling and draining the queue.
      filling = 1'b0;
      foreach (idle_pct[ph]) begin
         for (int n = 0; n < RandomPerPhase; n++) begin
            if ($urandom_range(29) == 0) filling = ~filling;
            roll = $urandom_range(99);
            if (roll < 3)
               op = OpUnused;
            else if (roll < 20)
               op = spq_pkg::OpTop;
            else if (roll < (filling ? 85 : 40))
               op = spq_pkg::OpInsert;
            else
               op = spq_pkg::OpPop;
            issue_command(op, $urandom, pick_priority(), idle_pct[ph]);
         end
      end
      start <= 1'b0;

      // Drain outstanding results, then allow for the registered result.
      drain_cycles = 0;
      @(negedge clock);
      while (open_count != 0 && drain_cycles < 100) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (open_count != 0)
         $display("%0t: %0d results never arrived", $time, open_count);

      if (fail_count == 0 && open_count == 0) begin
         $display("sorted_priority_queue verification clean");
      end else begin
         $display("sorted_priority_queue verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("sorted_priority_queue verification failed");
      $finish;
   end

endmodule
